// File: sv/lld_pkg.sv
package lld_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int LOAD_W          = 32;
    localparam int SVC_W           = 16;
    localparam int CNT_W           = 5;
    localparam int IDX_OUT_W       = 4;
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);

    typedef struct packed {
        logic [SVC_W-1:0] service_time;
        logic             start_batch;
    } t_in;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] assigned_server;
        logic [LOAD_W-1:0]    assigned_finish;
        logic [IDX_OUT_W-1:0] next_server;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_UPD,
        ST_SCAN2,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic scan_start;
        logic write;
        logic load_out;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } t_sts;

endpackage

// File: sv/least_loaded_server_dispatch.sv
// Each job makes two sequential scans of the load RAM read port (one entry per cycle):
//   one scan to pick the least-loaded server and one for next_server. A new job is
//   accepted only in idle, after the previous result is handed to the output register;
//   a result is loaded there only once the previous one has been accepted.
// Reset: synchronous active-low; loads read as zero (valid bits cleared), server_count = 1.
//   No clearing pass: start_batch clears all valid bits when its job is accepted.
module least_loaded_server_dispatch #(
    parameter int MAX_SERVERS = lld_pkg::MAX_SERVERS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // job input
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  lld_pkg::t_in              i_in_data,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output lld_pkg::t_out             o_out_data,
    // server_count write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lld_pkg::CNT_W-1:0] i_cfg_data
);
    import lld_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // config writes land whenever offered; the user must issue them only while idle (not enforced here)
    assign o_cfg_ready = 1'b1;

    // FSM: idle -> scan for least load -> write sum -> rescan -> hand off result.
    // Output register frees the datapath once the result is loaded.
    lld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // Load RAM, valid bits, scan/argmin engine, saturating adder, output register.
    lld_datapath #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_ctl       (ctl),
        .o_sts       (sts)
    );

endmodule

// File: sv/lld_ram.sv
module lld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/lld_ctrl.sv
module lld_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lld_pkg::t_sts i_sts,
    output lld_pkg::t_ctl o_ctl
);
    import lld_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN1;
            end
            ST_SCAN1: begin
                if (i_sts.scan_done) n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = ST_SCAN2;
            end
            ST_SCAN2: begin
                if (i_sts.scan_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_busy) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_ctl            = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_ctl.accept     = i_in_valid;
                o_ctl.scan_start = i_in_valid;
            end
            ST_UPD: begin
                o_ctl.write      = 1'b1;
                o_ctl.scan_start = 1'b1;
            end
            ST_DONE: begin
                o_ctl.load_out   = !i_sts.out_busy;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

// File: sv/lld_datapath.sv
module lld_datapath #(
    parameter int MAX_SERVERS = lld_pkg::MAX_SERVERS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lld_pkg::t_in              i_in_data,
    input  logic                      i_cfg_valid,
    input  logic [lld_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output lld_pkg::t_out             o_out_data,
    input  lld_pkg::t_ctl             i_ctl,
    output lld_pkg::t_sts             o_sts
);
    import lld_pkg::*;

    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW = $clog2(MAX_SERVERS + 1);

    // config and job registers
    logic [CNT_W-1:0]       r_count;
    logic [CW-1:0]          r_n;
    logic [CW-1:0]          n_n;
    logic [SVC_W-1:0]       r_svc;

    // load validity: an entry not valid reads as zero
    logic [MAX_SERVERS-1:0] r_vld;

    // scan engine
    logic                   r_issuing;
    logic [IW-1:0]          r_addr;
    logic                   r_pend;
    logic                   r_pend_last;
    logic                   r_pend_ev;
    logic [IW-1:0]          r_pend_idx;
    logic [IW-1:0]          r_best_idx;
    logic [LOAD_W-1:0]      r_best_load;
    logic [LOAD_W-1:0]      rdata;
    logic [LOAD_W-1:0]      ev;
    logic                   take;
    logic                   addr_last;

    // update
    logic [LOAD_W:0]        sum;
    logic [LOAD_W-1:0]      fin;
    logic [IW-1:0]          r_pick;
    logic [LOAD_W-1:0]      r_fin;

    // output register
    logic                   r_out_vld;
    t_out                   r_out;

    always_comb begin
        if (r_count == '0) begin
            n_n = CW'(1);
        end else if (int'(r_count) > MAX_SERVERS) begin
            n_n = CW'(MAX_SERVERS);
        end else begin
            n_n = CW'(r_count);
        end
    end

    lld_ram #(
        .WIDTH (LOAD_W),
        .DEPTH (MAX_SERVERS),
        .AW    (IW)
    ) u_load_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.write),
        .i_waddr (r_best_idx),
        .i_wdata (fin),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    assign addr_last = (CW'(r_addr) == (r_n - CW'(1)));
    assign ev        = r_pend_ev ? rdata : '0;
    assign take      = (r_pend_idx == '0) || (ev < r_best_load);
    assign sum       = {1'b0, r_best_load} + (LOAD_W + 1)'(r_svc);
    assign fin       = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_RESET;
            r_vld       <= '0;
            r_issuing   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) r_count <= i_cfg_data;

            if (i_ctl.accept && i_in_data.start_batch) begin
                r_vld <= '0;
            end else if (i_ctl.write) begin
                r_vld[r_best_idx] <= 1'b1;
            end

            if (i_ctl.scan_start) begin
                r_issuing <= 1'b1;
            end else if (r_issuing && addr_last) begin
                r_issuing <= 1'b0;
            end
            r_pend <= r_issuing;

            if (i_ctl.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_svc <= i_in_data.service_time;
            r_n   <= n_n;
        end
        if (i_ctl.scan_start) begin
            r_addr <= '0;
        end else if (r_issuing && !addr_last) begin
            r_addr <= r_addr + IW'(1);
        end
        r_pend_idx  <= r_addr;
        r_pend_last <= addr_last;
        r_pend_ev   <= r_vld[r_addr];
        if (r_pend && take) begin
            r_best_idx  <= r_pend_idx;
            r_best_load <= ev;
        end
        if (i_ctl.write) begin
            r_pick <= r_best_idx;
            r_fin  <= fin;
        end
        if (i_ctl.load_out) begin
            r_out.assigned_server <= IDX_OUT_W'(r_pick);
            r_out.assigned_finish <= r_fin;
            r_out.next_server     <= IDX_OUT_W'(r_best_idx);
        end
    end

    assign o_sts.scan_done = r_pend && r_pend_last;
    assign o_sts.out_busy  = r_out_vld && !i_out_ready;
    assign o_out_valid     = r_out_vld;
    assign o_out_data      = r_out;

endmodule
